// File: hw/rtl/pra_pkg.sv
package pra_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_RESERVE = 3'd1;
  localparam logic [2:0] REQ_ALLOC   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_BEGIN   = 3'd4;
  localparam logic [2:0] REQ_ABORT   = 3'd5;
  localparam logic [2:0] REQ_COMMIT  = 3'd6;

  localparam logic [1:0] CFG_ADDR_BITS     = 2'd0;
  localparam logic [1:0] CFG_LOCKED        = 2'd1;
  localparam logic [1:0] CFG_PAGE_BYTES    = 2'd2;
  localparam logic [1:0] CFG_RES_PAGE_BYTES = 2'd3;

  localparam logic [1:0] OWNER_BOOT     = 2'd0;
  localparam logic [1:0] OWNER_LOADER   = 2'd1;
  localparam logic [1:0] OWNER_RESIDENT = 2'd2;

  typedef struct packed {
    logic [62:0] start;
    logic [63:0] len;
    logic [3:0]  kind;
  } region_ent_t;

  typedef struct packed {
    logic [62:0] start;
    logic [63:0] len;
    logic [1:0]  owner;
    logic [31:0] txn;
  } grant_ent_t;

  function automatic logic overlaps(input logic [63:0] a, input logic [63:0] a_end,
                                    input logic [63:0] b, input logic [63:0] b_end);
    return (a < b_end) && (b < a_end);
  endfunction

  function automatic logic range_ok(input logic [5:0] abits, input logic [62:0] base,
                                    input logic [63:0] size);
    logic [63:0] lim;
    lim = 64'd1 << abits;
    return (abits >= 6'd32) && (size != 64'd0) && ({1'b0, base} < lim) &&
           (size <= lim - {1'b0, base});
  endfunction

endpackage

// File: hw/rtl/pra_req_if.sv
interface pra_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [62:0] range_base;
  logic [63:0] range_size;
  logic [3:0]  region_kind;
  logic [1:0]  owner;
  logic [63:0] align_bytes;
  logic [63:0] lower_bound;
  logic [63:0] upper_bound;

  modport source(output valid, req_type, range_base, range_size, region_kind, owner,
                 align_bytes, lower_bound, upper_bound, input ready);
  modport sink(input valid, req_type, range_base, range_size, region_kind, owner,
               align_bytes, lower_bound, upper_bound, output ready);
endinterface

// File: hw/rtl/pra_res_if.sv
interface pra_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [62:0] granted_base;

  modport source(output valid, status, granted_base, input ready);
  modport sink(input valid, status, granted_base, output ready);
endinterface

// File: hw/rtl/physical_region_allocator_core.sv
// Physical region allocator. Keeps a base-sorted region table and an unordered
// grant table, each in a single-port-write, registered-read memory, and serves
// one request at a time through a sequencer; a new request is taken only when
// the previous one has finished, while its result may still sit in the output
// register. Add walks the regions below the new base, then shifts the regions
// above it up; reserve, release and commit scan the grant table, and abort
// also drops each grant of the open transaction. Allocate walks free regions
// from the top and, for every candidate base, scans the grant table; each
// grant hit lowers the window and starts a new scan, so the cost grows with
// regions times grants.
module physical_region_allocator_core #(
  parameter int REGION_SLOTS    = 64,
  parameter int GRANT_SLOTS     = 64,
  parameter int REGION_KIND_MAX = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  pra_req_if.sink     req,
  pra_res_if.source   res
);
  import pra_pkg::*;

  localparam int RIW = $clog2(REGION_SLOTS);
  localparam int RCW = $clog2(REGION_SLOTS + 1);
  localparam int GIW = $clog2(GRANT_SLOTS);
  localparam int GCW = $clog2(GRANT_SLOTS + 1);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_CHECK    = 18'h00002,
    S_PREP     = 18'h00004,
    S_ADD_RD   = 18'h00008,
    S_ADD_EX   = 18'h00010,
    S_SHIFT_RD = 18'h00020,
    S_SHIFT_WR = 18'h00040,
    S_INSERT   = 18'h00080,
    S_REG_RD   = 18'h00100,
    S_REG_EX   = 18'h00200,
    S_WIN      = 18'h00400,
    S_BASE     = 18'h00800,
    S_GSCAN_RD = 18'h01000,
    S_GSCAN_EX = 18'h02000,
    S_GRANT_WR = 18'h04000,
    S_DROP_RD  = 18'h08000,
    S_DROP_WR  = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  state_t state;

  logic [5:0]  addr_bits;
  logic        locked;
  logic [32:0] page_bytes;
  logic [32:0] res_page_bytes;

  logic [2:0]  q_type;
  logic [62:0] q_base;
  logic [63:0] q_size;
  logic [3:0]  q_kind;
  logic [1:0]  q_owner;
  logic [63:0] q_align;
  logic [63:0] q_lo;
  logic [63:0] q_hi;

  logic [63:0] cur_base;
  logic [63:0] cur_end;
  logic [63:0] cur_size;
  logic [63:0] amask;
  logic [63:0] win_low;
  logic [63:0] win_end;

  logic [RCW-1:0] rcount;
  logic [RCW-1:0] ridx;
  logic [RCW-1:0] sj;
  logic [GCW-1:0] gcount;
  logic [GCW-1:0] gidx;
  region_ent_t    prev;

  logic [31:0] open_txn;
  logic [31:0] txn_counter;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [62:0] out_base;

  // region table memory
  region_ent_t region_mem [REGION_SLOTS];
  region_ent_t r_rdata, r_wdata;
  logic [RIW-1:0] r_raddr, r_waddr;
  logic r_we;

  always_ff @(posedge clk) begin
    if (r_we) region_mem[r_waddr] <= r_wdata;
    r_rdata <= region_mem[r_raddr];
  end

  // grant table memory
  grant_ent_t grant_mem [GRANT_SLOTS];
  grant_ent_t g_rdata, g_wdata;
  logic [GIW-1:0] g_raddr, g_waddr;
  logic g_we;

  always_ff @(posedge clk) begin
    if (g_we) grant_mem[g_waddr] <= g_wdata;
    g_rdata <= grant_mem[g_raddr];
  end

  logic [RCW-1:0] sj_dec, ridx_dec;
  logic [GCW-1:0] gcount_dec;
  logic [63:0] r_end, g_end, prev_end;
  logic        ov_prev, ov_cur, ov_grant, txn_hit;

  assign sj_dec     = sj - 1'b1;
  assign ridx_dec   = ridx - 1'b1;
  assign gcount_dec = gcount - 1'b1;
  assign r_end      = {1'b0, r_rdata.start} + r_rdata.len;
  assign g_end      = {1'b0, g_rdata.start} + g_rdata.len;
  assign prev_end   = {1'b0, prev.start} + prev.len;
  assign ov_prev    = (ridx != '0) && overlaps({1'b0, q_base}, cur_end, {1'b0, prev.start},
                                               prev_end);
  assign ov_cur     = overlaps({1'b0, q_base}, cur_end, {1'b0, r_rdata.start}, r_end);
  assign ov_grant   = overlaps(cur_base, cur_end, {1'b0, g_rdata.start}, g_end);
  assign txn_hit    = g_rdata.txn == open_txn;

  always_comb begin
    case (state)
      S_SHIFT_RD: r_raddr = sj_dec[RIW-1:0];
      S_REG_RD:   r_raddr = ridx_dec[RIW-1:0];
      default:    r_raddr = ridx[RIW-1:0];
    endcase
    r_we    = (state == S_SHIFT_WR) || (state == S_INSERT);
    r_waddr = (state == S_SHIFT_WR) ? sj[RIW-1:0] : ridx[RIW-1:0];
    r_wdata = (state == S_SHIFT_WR) ? r_rdata : region_ent_t'{q_base, q_size, q_kind};

    g_raddr = (state == S_DROP_RD) ? gcount_dec[GIW-1:0] : gidx[GIW-1:0];
    g_we    = (state == S_GRANT_WR) || (state == S_DROP_WR) ||
              ((state == S_GSCAN_EX) && (q_type == REQ_COMMIT) && txn_hit);
    g_waddr = (state == S_GRANT_WR) ? gcount[GIW-1:0] : gidx[GIW-1:0];
    case (state)
      S_GRANT_WR: g_wdata = grant_ent_t'{cur_base[62:0], cur_size, q_owner,
                                         (q_owner == OWNER_LOADER) ? open_txn : 32'd0};
      S_DROP_WR:  g_wdata = g_rdata;
      default:    g_wdata = grant_ent_t'{g_rdata.start, g_rdata.len, g_rdata.owner, 32'd0};
    endcase
  end

  // allocation granularity and checks
  logic [32:0] gran;
  logic [63:0] gran_m1, align_eff;
  logic [64:0] round_sum;
  logic [63:0] lim;
  logic        alloc_ok, owner_ok;

  assign gran      = ((q_owner == OWNER_RESIDENT) && (res_page_bytes != '0)) ?
                     res_page_bytes : page_bytes;
  assign gran_m1   = {31'd0, gran} - 64'd1;
  assign round_sum = {1'b0, q_size} + {1'b0, gran_m1};
  assign align_eff = (q_align < {31'd0, gran}) ? {31'd0, gran} : q_align;
  assign lim       = 64'd1 << addr_bits;
  assign owner_ok  = (q_owner <= OWNER_RESIDENT) &&
                     !((q_owner == OWNER_LOADER) && (open_txn == 32'd0));
  assign alloc_ok  = (addr_bits >= 6'd32) && (q_size != 64'd0) && owner_ok &&
                     (q_align != 64'd0) && ((q_align & (q_align - 64'd1)) == 64'd0) &&
                     (q_lo < q_hi) && (q_hi <= lim);

  // first decision on a request
  logic [1:0] chk_status;
  state_t     chk_state;
  logic       begin_ok;

  assign begin_ok = (open_txn == 32'd0) && (txn_counter != 32'hFFFF_FFFF);

  always_comb begin
    chk_status = ST_INVALID;
    chk_state  = S_DONE;
    if (!locked) begin
      case (q_type)
        REQ_ADD: begin
          if (range_ok(addr_bits, q_base, q_size) &&
              (q_kind <= 4'(REGION_KIND_MAX))) begin
            if (rcount == RCW'(REGION_SLOTS)) chk_status = ST_NOSPACE;
            else chk_state = S_ADD_RD;
          end
        end
        REQ_RESERVE: begin
          if (range_ok(addr_bits, q_base, q_size) && owner_ok) begin
            if (gcount == GCW'(GRANT_SLOTS)) chk_status = ST_NOSPACE;
            else chk_state = S_GSCAN_RD;
          end
        end
        REQ_ALLOC: begin
          if (alloc_ok) chk_state = S_PREP;
        end
        REQ_RELEASE: chk_state = S_GSCAN_RD;
        REQ_BEGIN: begin
          if (begin_ok) chk_status = ST_OK;
        end
        REQ_ABORT, REQ_COMMIT: begin
          if (open_txn != 32'd0) chk_state = S_GSCAN_RD;
        end
        default: ;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.granted_base = out_base;

  logic [1:0]  fin_status;
  logic [62:0] fin_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      addr_bits      <= 6'd48;
      locked         <= 1'b0;
      page_bytes     <= 33'd4096;
      res_page_bytes <= 33'd0;
      rcount         <= '0;
      gcount         <= '0;
      open_txn       <= 32'd0;
      txn_counter    <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDR_BITS:      addr_bits      <= cfg_data[5:0];
          CFG_LOCKED:         locked         <= cfg_data[0];
          CFG_PAGE_BYTES:     page_bytes     <= cfg_data;
          CFG_RES_PAGE_BYTES: res_page_bytes <= cfg_data;
          default: ;
        endcase
      end
      if ((state == S_DONE) && (!out_valid || res.ready)) out_valid <= 1'b1;
      else if (out_valid && res.ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            q_type  <= req.req_type;
            q_base  <= req.range_base;
            q_size  <= req.range_size;
            q_kind  <= req.region_kind;
            q_owner <= req.owner;
            q_align <= req.align_bytes;
            q_lo    <= req.lower_bound;
            q_hi    <= req.upper_bound;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          fin_status <= chk_status;
          fin_base   <= '0;
          cur_base   <= {1'b0, q_base};
          cur_end    <= {1'b0, q_base} + q_size;
          cur_size   <= q_size;
          ridx       <= '0;
          gidx       <= '0;
          state      <= chk_state;
          if (!locked && (q_type == REQ_BEGIN) && begin_ok) begin
            txn_counter <= txn_counter + 32'd1;
            open_txn    <= txn_counter + 32'd1;
          end
        end
        S_PREP: begin
          ridx <= rcount;
          if (gran == '0) begin
            amask <= ~(q_align - 64'd1);
            state <= S_REG_RD;
          end else if (round_sum[64]) begin
            state <= S_DONE;
          end else begin
            cur_size <= round_sum[63:0] & ~gran_m1;
            amask    <= ~(align_eff - 64'd1);
            state    <= S_REG_RD;
          end
        end
        S_ADD_RD: begin
          if (ridx == rcount) begin
            if (ov_prev) state <= S_DONE;
            else begin
              sj    <= rcount;
              state <= S_SHIFT_RD;
            end
          end else begin
            state <= S_ADD_EX;
          end
        end
        S_ADD_EX: begin
          if (r_rdata.start < q_base) begin
            prev  <= r_rdata;
            ridx  <= ridx + 1'b1;
            state <= S_ADD_RD;
          end else if (ov_prev || ov_cur) begin
            state <= S_DONE;
          end else begin
            sj    <= rcount;
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: state <= (sj == ridx) ? S_INSERT : S_SHIFT_WR;
        S_SHIFT_WR: begin
          sj    <= sj_dec;
          state <= S_SHIFT_RD;
        end
        S_INSERT: begin
          rcount     <= rcount + 1'b1;
          fin_status <= ST_OK;
          state      <= S_DONE;
        end
        // walk regions from the top
        S_REG_RD: begin
          if (ridx == '0) begin
            fin_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            state <= S_REG_EX;
          end
        end
        S_REG_EX: begin
          ridx <= ridx_dec;
          if (r_rdata.kind != 4'd0) state <= S_REG_RD;
          else begin
            win_low <= ({1'b0, r_rdata.start} > q_lo) ? {1'b0, r_rdata.start} : q_lo;
            win_end <= (r_end > q_hi) ? q_hi : r_end;
            state   <= S_WIN;
          end
        end
        S_WIN: begin
          if ((win_end > win_low) && (cur_size <= win_end - win_low)) begin
            cur_base <= (win_end - cur_size) & amask;
            state    <= S_BASE;
          end else begin
            state <= S_REG_RD;
          end
        end
        S_BASE: begin
          gidx <= '0;
          if (cur_base < win_low) state <= S_REG_RD;
          else begin
            cur_end <= cur_base + cur_size;
            state   <= S_GSCAN_RD;
          end
        end
        S_GSCAN_RD: begin
          if (gidx == gcount) begin
            case (q_type)
              REQ_RESERVE: state <= S_GRANT_WR;
              REQ_ALLOC: begin
                if (gcount == GCW'(GRANT_SLOTS)) state <= S_DONE;
                else state <= S_GRANT_WR;
              end
              REQ_ABORT, REQ_COMMIT: begin
                open_txn   <= 32'd0;
                fin_status <= ST_OK;
                state      <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end else begin
            state <= S_GSCAN_EX;
          end
        end
        S_GSCAN_EX: begin
          case (q_type)
            REQ_RESERVE: begin
              if (ov_grant) state <= S_DONE;
              else begin
                gidx  <= gidx + 1'b1;
                state <= S_GSCAN_RD;
              end
            end
            REQ_ALLOC: begin
              // first hit lowers the window top and retries
              if (ov_grant) begin
                win_end <= {1'b0, g_rdata.start};
                state   <= S_WIN;
              end else begin
                gidx  <= gidx + 1'b1;
                state <= S_GSCAN_RD;
              end
            end
            REQ_RELEASE: begin
              if (g_rdata.start == q_base) begin
                state <= (g_rdata.owner != OWNER_BOOT) ? S_DONE : S_DROP_RD;
              end else begin
                gidx  <= gidx + 1'b1;
                state <= S_GSCAN_RD;
              end
            end
            REQ_ABORT: begin
              if (txn_hit) state <= S_DROP_RD;
              else begin
                gidx  <= gidx + 1'b1;
                state <= S_GSCAN_RD;
              end
            end
            default: begin
              gidx  <= gidx + 1'b1;
              state <= S_GSCAN_RD;
            end
          endcase
        end
        S_GRANT_WR: begin
          gcount     <= gcount + 1'b1;
          fin_status <= ST_OK;
          fin_base   <= (q_type == REQ_ALLOC) ? cur_base[62:0] : '0;
          state      <= S_DONE;
        end
        S_DROP_RD: state <= S_DROP_WR;
        S_DROP_WR: begin
          gcount <= gcount_dec;
          if (q_type == REQ_RELEASE) begin
            fin_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            state <= S_GSCAN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_status <= fin_status;
            out_base   <= (fin_status == ST_OK) ? fin_base : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rcount_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= RCW'(REGION_SLOTS)) else $error("region count overflow");
  a_gcount_bound: assert property (@(posedge clk) disable iff (rst)
    gcount <= GCW'(GRANT_SLOTS)) else $error("grant count overflow");
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CHECK) else $error("request not checked");
  a_txn_order: assert property (@(posedge clk) disable iff (rst)
    open_txn != 32'd0 |-> open_txn == txn_counter) else $error("open txn mismatch");
  a_base_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.granted_base == '0)
    else $error("base on failed request");
`endif

endmodule

// File: bench/physical_region_allocator_core_chk.sv
module physical_region_allocator_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  pra_req_if          req,
  pra_res_if          res,
  output int          fails,
  output int          pending
);
  import pra_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [62:0] granted_base;
  } answer_t;

  answer_t answers_due[$];

  logic [5:0]  abits;
  logic        lock;
  logic [32:0] page;
  logic [32:0] res_page;

  logic [62:0] reg_start [64];
  logic [63:0] reg_len   [64];
  logic [3:0]  reg_kind  [64];
  int          reg_count;
  logic [62:0] gr_start  [64];
  logic [63:0] gr_len    [64];
  logic [1:0]  gr_owner  [64];
  logic [31:0] gr_txn    [64];
  int          gr_count;
  logic [31:0] open_id;
  logic [31:0] id_ctr;

  assign pending = answers_due.size();

  function automatic logic width_ok();
    return abits >= 6'd32;
  endfunction

  function automatic logic span_ok(input logic [63:0] base, input logic [63:0] size);
    logic [63:0] lim;
    lim = 64'd1 << abits;
    if (!width_ok() || size == 64'd0) return 1'b0;
    return base < lim && size <= lim - base;
  endfunction

  function automatic logic hits(input logic [63:0] a, input logic [63:0] n,
                                input logic [63:0] b, input logic [63:0] s);
    logic [63:0] a_end, b_end;
    a_end = a + n;
    b_end = b + s;
    return a < b_end && b < a_end;
  endfunction

  function automatic void drop_grant(input int i);
    gr_count--;
    gr_start[i] = gr_start[gr_count];
    gr_len[i]   = gr_len[gr_count];
    gr_owner[i] = gr_owner[gr_count];
    gr_txn[i]   = gr_txn[gr_count];
  endfunction

  function automatic logic [1:0] add_region(input logic [63:0] base, input logic [63:0] size,
                                            input logic [3:0] kind);
    int i;
    i = 0;
    if (!span_ok(base, size) || kind > 4'd7) return ST_INVALID;
    if (reg_count >= 64) return ST_NOSPACE;
    while (i < reg_count && {1'b0, reg_start[i]} < base) i++;
    if (i > 0 && hits(base, size, {1'b0, reg_start[i-1]}, reg_len[i-1])) return ST_INVALID;
    if (i < reg_count && hits(base, size, {1'b0, reg_start[i]}, reg_len[i])) return ST_INVALID;
    for (int j = reg_count; j > i; j--) begin
      reg_start[j] = reg_start[j-1];
      reg_len[j]   = reg_len[j-1];
      reg_kind[j]  = reg_kind[j-1];
    end
    reg_start[i] = base[62:0];
    reg_len[i]   = size;
    reg_kind[i]  = kind;
    reg_count++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] take_range(input logic [63:0] base, input logic [63:0] size,
                                            input logic [1:0] who);
    if (!span_ok(base, size) || who > OWNER_RESIDENT ||
        (who == OWNER_LOADER && open_id == 32'd0)) return ST_INVALID;
    if (gr_count >= 64) return ST_NOSPACE;
    for (int i = 0; i < gr_count; i++)
      if (hits(base, size, {1'b0, gr_start[i]}, gr_len[i])) return ST_INVALID;
    gr_start[gr_count] = base[62:0];
    gr_len[gr_count]   = size;
    gr_owner[gr_count] = who;
    gr_txn[gr_count]   = (who == OWNER_LOADER) ? open_id : 32'd0;
    gr_count++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] place(input logic [1:0] who, input logic [63:0] size_in,
                                       input logic [63:0] align_in, input logic [63:0] lo,
                                       input logic [63:0] hi, output logic [63:0] got);
    logic [63:0] gran, size, align, low, top, base;
    logic [1:0]  st;
    int          j;
    logic        blocked;
    size  = size_in;
    align = align_in;
    got   = 64'd0;
    if (!width_ok() || size == 0 || who > OWNER_RESIDENT ||
        (who == OWNER_LOADER && open_id == 32'd0) || align == 0 ||
        (align & (align - 64'd1)) != 0 || lo >= hi || hi > (64'd1 << abits))
      return ST_INVALID;
    gran = (who == OWNER_RESIDENT && res_page != 0) ? {31'd0, res_page} : {31'd0, page};
    if (gran != 0) begin
      if (size > ~64'd0 - (gran - 64'd1)) return ST_INVALID;
      size = (size + gran - 64'd1) & ~(gran - 64'd1);
      if (align < gran) align = gran;
    end
    for (int i = reg_count; i > 0; i--) begin
      if (reg_kind[i-1] != 4'd0) continue;
      low = ({1'b0, reg_start[i-1]} > lo) ? {1'b0, reg_start[i-1]} : lo;
      top = {1'b0, reg_start[i-1]} + reg_len[i-1];
      if (top > hi) top = hi;
      while (top > low && size <= top - low) begin
        base = (top - size) & ~(align - 64'd1);
        if (base < low) break;
        blocked = 1'b0;
        for (j = 0; j < gr_count && !blocked; j++)
          if (hits(base, size, {1'b0, gr_start[j]}, gr_len[j])) begin
            top = {1'b0, gr_start[j]};
            blocked = 1'b1;
          end
        if (blocked) continue;
        if (gr_count >= 64) return ST_INVALID;
        st = take_range(base, size, who);
        if (st == ST_OK) got = base;
        return st;
      end
    end
    return ST_NOSPACE;
  endfunction

  function automatic logic [1:0] give_back(input logic [63:0] base);
    for (int i = 0; i < gr_count; i++) begin
      if ({1'b0, gr_start[i]} != base) continue;
      if (gr_owner[i] != OWNER_BOOT) return ST_INVALID;
      drop_grant(i);
      return ST_OK;
    end
    return ST_INVALID;
  endfunction

  function automatic answer_t serve_request();
    answer_t     a;
    logic [63:0] got;
    int          i;
    a.status = ST_INVALID;
    got = 64'd0;
    if (!lock) begin
      case (req.req_type)
        REQ_ADD:     a.status = add_region({1'b0, req.range_base}, req.range_size,
                                           req.region_kind);
        REQ_RESERVE: a.status = take_range({1'b0, req.range_base}, req.range_size, req.owner);
        REQ_ALLOC:   a.status = place(req.owner, req.range_size, req.align_bytes,
                                      req.lower_bound, req.upper_bound, got);
        REQ_RELEASE: a.status = give_back({1'b0, req.range_base});
        REQ_BEGIN: begin
          if (open_id == 0 && id_ctr != 32'hffff_ffff) begin
            id_ctr++;
            open_id = id_ctr;
            a.status = ST_OK;
          end
        end
        REQ_ABORT: begin
          if (open_id != 0) begin
            i = 0;
            while (i < gr_count) begin
              if (gr_txn[i] == open_id) drop_grant(i);
              else i++;
            end
            open_id = 0;
            a.status = ST_OK;
          end
        end
        REQ_COMMIT: begin
          if (open_id != 0) begin
            for (int k = 0; k < gr_count; k++)
              if (gr_txn[k] == open_id) gr_txn[k] = 0;
            open_id = 0;
            a.status = ST_OK;
          end
        end
        default: ;
      endcase
    end
    if (a.status != ST_OK) got = 64'd0;
    a.granted_base = got[62:0];
    return a;
  endfunction

  task automatic report(input string what, input logic [62:0] seen, input logic [62:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, seen, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      abits = 6'd48; lock = 1'b0; page = 33'd4096; res_page = 33'd0;
      reg_count = 0; gr_count = 0; open_id = 0; id_ctr = 0;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDR_BITS:      abits    = cfg_data[5:0];
          CFG_LOCKED:         lock     = cfg_data[0];
          CFG_PAGE_BYTES:     page     = cfg_data;
          CFG_RES_PAGE_BYTES: res_page = cfg_data;
          default: ;
        endcase
      end
      // result first: one accepted on the same edge belongs to an older request
      if (res.valid && res.ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected result", res.granted_base, 63'd0);
        end else begin
          a = answers_due.pop_front();
          if (res.status !== a.status) report("status", res.status, a.status);
          if (res.granted_base !== a.granted_base)
            report("granted_base", res.granted_base, a.granted_base);
        end
      end
      if (req.valid && req.ready) answers_due.push_back(serve_request());
    end
  end

endmodule

// File: bench/physical_region_allocator_core_tb.sv
module physical_region_allocator_core_tb;
  import pra_pkg::*;

  localparam int IDLE_LIMIT = 1500000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [32:0] cfg_data;
  int          fails;
  int          pending;
  int          src_idle;
  int          snk_idle;
  logic        hold_go;
  int          hold_left;
  int          quiet;
  logic [62:0] base_pool[$];

  pra_req_if req ();
  pra_res_if res ();

  physical_region_allocator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .res(res)
  );

  physical_region_allocator_core_chk chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .res(res), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = CFG_ADDR_BITS; cfg_data = '0;
    req.valid = 1'b0; req.req_type = REQ_BEGIN; req.range_base = '0; req.range_size = '0;
    req.region_kind = '0; req.owner = OWNER_BOOT; req.align_bytes = '0;
    req.lower_bound = '0; req.upper_bound = '0;
    res.ready = 1'b0; hold_go = 1'b0; hold_left = 0;
    src_idle = 0; snk_idle = 0;
  end

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_go) begin
      hold_left = 400;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // granted bases feed later release requests
  always @(posedge clk)
    if (!rst && res.valid && res.ready && res.status == ST_OK && res.granted_base != 0)
      base_pool.push_back(res.granted_base);

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("physical_region_allocator_core: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input logic [2:0] t, input logic [62:0] base, input logic [63:0] size,
                      input logic [3:0] kind, input logic [1:0] who, input logic [63:0] al,
                      input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1; req.req_type <= t; req.range_base <= base; req.range_size <= size;
    req.region_kind <= kind; req.owner <= who; req.align_bytes <= al;
    req.lower_bound <= lo; req.upper_bound <= hi;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
    req.valid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    // let the last accepted request be queued by the checker before polling pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_request(input logic [63:0] space);
    int          pick;
    logic [62:0] b;
    pick = $urandom_range(99);
    b = 63'($urandom_range(0, 4095)) << 12;
    if (pick < 12) begin
      send(REQ_ADD, 63'($urandom_range(0, 15)) << 20,
           ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 1 << 20))
                                      : 64'($urandom_range(1, 256)) << 12,
           ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 8)) : 4'd0,
           OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    end else if (pick < 22) begin
      base_pool.push_back(b);
      send(REQ_RESERVE, b, 64'($urandom_range(1, 16)) << 12, 4'd0,
           2'($urandom_range(0, 2)), 64'd1, 64'd0, 64'd0);
    end else if (pick < 52) begin
      send(REQ_ALLOC, 63'(r64()), 64'($urandom_range(1, 40000)), 4'($urandom),
           2'($urandom_range(0, 2)), 64'd1 << $urandom_range(0, 18),
           ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 1 << 23)) : 64'd0,
           ($urandom_range(0, 2) == 0) ? space : 64'd1 << 24);
    end else if (pick < 66) begin
      if (base_pool.size() > 0 && $urandom_range(0, 3) != 0)
        b = base_pool[$urandom_range(0, base_pool.size() - 1)];
      send(REQ_RELEASE, b, r64(), 4'($urandom), OWNER_BOOT, r64(), r64(), r64());
    end else if (pick < 76) begin
      send(REQ_BEGIN, 63'(r64()), r64(), 4'($urandom), 2'($urandom), r64(), r64(), r64());
    end else if (pick < 83) begin
      send(REQ_ABORT, 63'(r64()), r64(), 4'($urandom), 2'($urandom), r64(), r64(), r64());
    end else if (pick < 90) begin
      send(REQ_COMMIT, 63'(r64()), r64(), 4'($urandom), 2'($urandom), r64(), r64(), r64());
    end else begin
      // raw noise over every field bit
      send(3'($urandom), 63'(r64()), r64(), 4'($urandom), 2'($urandom),
           ($urandom_range(0, 1) == 0) ? r64() : 64'd1 << $urandom_range(0, 63),
           r64(), r64());
    end
  endtask

  logic [5:0]  ph_bits [6] = '{6'd32, 6'd63, 6'd40, 6'd48, 6'd31, 6'd0};
  logic        ph_lock [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  logic [32:0] ph_page [6] = '{33'd4096, 33'd0, 33'h1_0000_0000, 33'd65536, 33'd4096, 33'd1};
  logic [32:0] ph_rpage[6] = '{33'd65536, 33'd0, 33'd4096, 33'h1_0000_0000, 33'd0, 33'd2};
  int          ph_items[6] = '{240, 180, 150, 40, 40, 40};

  initial begin
    logic [63:0] space;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, at reset settings
    src_idle = 12; snk_idle = 79;
    send(REQ_ADD, 63'h10_0000, 64'h10_0000, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_ADD, 63'h30_0000, 64'h8_0000, 4'd1, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_ADD, 63'h18_0000, 64'h1000, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_ADD, 63'h40_0000, 64'h1000, 4'd8, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_ADD, 63'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 4'd15, OWNER_BOOT,
         64'd1, 64'd0, 64'd0);
    send(REQ_ADD, 63'h50_0000, 64'd0, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_RESERVE, 63'h1f_f000, 64'h1000, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd0);
    send(REQ_RESERVE, 63'h1f_f800, 64'h10, 4'd0, OWNER_RESIDENT, 64'd1, 64'd0, 64'd0);
    send(REQ_RESERVE, 63'h60_0000, 64'h1000, 4'd0, OWNER_LOADER, 64'd1, 64'd0, 64'd0);
    send(REQ_RESERVE, 63'h60_0000, 64'h1000, 4'd0, 2'd3, 64'd1, 64'd0, 64'd0);
    send(REQ_ALLOC, '0, 64'd5000, 4'd0, OWNER_BOOT, 64'd16, 64'd0, 64'd1 << 48);
    send(REQ_ALLOC, '0, 64'd1, 4'd0, OWNER_RESIDENT, 64'h8000_0000_0000_0000, 64'd0,
         64'h8000_0000_0000_0000);
    send(REQ_ALLOC, '0, 64'd100, 4'd0, OWNER_BOOT, 64'd0, 64'd0, 64'd1 << 30);
    send(REQ_ALLOC, '0, 64'd100, 4'd0, OWNER_BOOT, 64'd12, 64'd0, 64'd1 << 30);
    send(REQ_ALLOC, '0, 64'd100, 4'd0, OWNER_BOOT, 64'd1, 64'd50, 64'd50);
    send(REQ_ALLOC, '0, 64'hffff_ffff_ffff_ffff, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd1 << 40);
    send(REQ_ALLOC, '0, 64'h100_0000, 4'd0, OWNER_BOOT, 64'd1, 64'd0, 64'd1 << 40);
    send(REQ_BEGIN, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_BEGIN, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_ALLOC, '0, 64'd8192, 4'd0, OWNER_LOADER, 64'd1, 64'd0, 64'd1 << 48);
    send(REQ_ABORT, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_ABORT, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_COMMIT, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_RELEASE, 63'h1f_f000, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(REQ_RELEASE, 63'h60_0000, '0, 4'd0, OWNER_BOOT, '0, '0, '0);
    send(3'd7, '0, '0, 4'd0, OWNER_BOOT, '0, '0, '0);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(CFG_ADDR_BITS, 33'(ph_bits[p]));
      write_reg(CFG_LOCKED, 33'(ph_lock[p]));
      write_reg(CFG_PAGE_BYTES, ph_page[p]);
      write_reg(CFG_RES_PAGE_BYTES, ph_rpage[p]);
      case (p % 3)
        0: begin src_idle = 12; snk_idle = 79; end
        1: begin src_idle = 79; snk_idle = 12; end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      space = (ph_bits[p] >= 6'd32) ? 64'd1 << ph_bits[p] : 64'd1 << 32;
      for (int n = 0; n < ph_items[p]; n++) begin
        // fill the block up while the receiver holds off
        if (p == 2 && n == 20) hold_go <= 1'b1;
        else if (p == 2 && n == 21) hold_go <= 1'b0;
        random_request(space);
      end
    end
    hold_go <= 1'b0;

    settle();
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("physical_region_allocator_core: match");
    end else begin
      $display("physical_region_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pra_pkg.sv
hw/rtl/pra_req_if.sv
hw/rtl/pra_res_if.sv
hw/rtl/physical_region_allocator_core.sv
bench/physical_region_allocator_core_chk.sv
bench/physical_region_allocator_core_tb.sv
